@@ hw/rtl/lru_guest_register_cache_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the guest register cache
// Clocked assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_GUEST_REGISTER_CACHE_TOP_MACROS_SVH
`define LRU_GUEST_REGISTER_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// implication checked on the same edge
`define LGRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent now, consequent on the next edge
`define LGRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LGRC_ASSERT(lbl, prop, msg)
`define LGRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/lgrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lgrc_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgrc_pkg;

  localparam int SLOT_COUNT  = 9;
  localparam int GUEST_COUNT = 32;

  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int GUEST_W     = 5;
  localparam int SLOT_W      = 4;
  localparam int VAL_W       = 32;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;

  // command codes
  localparam logic [1:0] CMD_USE   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // guest entry kinds
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_IMM  = 2'd1;
  localparam logic [1:0] K_REG  = 2'd2;

  // result actions
  localparam logic [1:0] A_STORE = 2'd0;
  localparam logic [1:0] A_LOAD  = 2'd1;
  localparam logic [1:0] A_MOVE  = 2'd2;
  localparam logic [1:0] A_DONE  = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SET       = 4'd2;
  localparam logic [3:0] OP_AGE       = 4'd3;
  localparam logic [3:0] OP_HIT       = 4'd4;
  localparam logic [3:0] OP_PICK_FREE = 4'd5;
  localparam logic [3:0] OP_SCAN_CLR  = 4'd6;
  localparam logic [3:0] OP_SCAN_STEP = 4'd7;
  localparam logic [3:0] OP_SPILL     = 4'd8;
  localparam logic [3:0] OP_FILL      = 4'd9;
  localparam logic [3:0] OP_DONE_USE  = 4'd10;
  localparam logic [3:0] OP_DONE_ZERO = 4'd11;
  localparam logic [3:0] OP_FCLR      = 4'd12;
  localparam logic [3:0] OP_FSTORE    = 4'd13;
  localparam logic [3:0] OP_FNEXT     = 4'd14;
  localparam logic [3:0] OP_FINISH    = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       gok;
    logic [1:0] kind;
    logic       has_free;
    logic       scan_last;
    logic       out_free;
    logic       fg_last;
    logic       flushing;
  } dp_stat_t;

  // a stored slot number that is out of range maps to slot 0
  function automatic logic [SLOT_IDX_W-1:0] slot_fix(input logic [SLOT_IDX_W-1:0] s);
    logic [SLOT_IDX_W:0] lim;
    lim = (SLOT_IDX_W + 1)'(SLOT_COUNT);
    slot_fix = ({1'b0, s} < lim) ? s : '0;
  endfunction

endpackage

@@ hw/rtl/lgrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgrc_ctrl
// Sequencer: steps the datapath through use, set-immediate and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lgrc_pkg::dp_stat_t stat,
  output lgrc_pkg::dp_cmd_t  cmd
);
  import lgrc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_HIT   = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SPILL = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_UDONE = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.cmd == CMD_USE && stat.gok) begin
          if (stat.kind == K_IMM) begin
            state_nxt = S_PICK;
          end else begin
            cmd.op    = OP_AGE;
            state_nxt = (stat.kind == K_REG) ? S_HIT : S_PICK;
          end
        end else if (stat.cmd == CMD_SET && stat.gok) begin
          cmd.op    = OP_SET;
          state_nxt = S_FIN;
        end else if (stat.cmd == CMD_FLUSH) begin
          cmd.op    = OP_FCLR;
          state_nxt = S_FCHK;
        end else begin
          cmd.op    = OP_DONE_ZERO;
          state_nxt = S_FIN;
        end
      end
      S_HIT: begin
        cmd.op    = OP_HIT;
        state_nxt = S_FIN;
      end
      S_PICK: begin
        if (stat.has_free) begin
          cmd.op    = OP_PICK_FREE;
          state_nxt = S_FILL;
        end else begin
          cmd.op    = OP_SCAN_CLR;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN_STEP;
        if (stat.scan_last) state_nxt = S_SPILL;
      end
      S_SPILL: begin
        if (stat.out_free) begin
          cmd.op    = OP_SPILL;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (stat.out_free) begin
          cmd.op    = OP_FILL;
          state_nxt = stat.flushing ? S_FCHK : S_UDONE;
        end
      end
      S_UDONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_DONE_USE;
          state_nxt = S_FIN;
        end
      end
      S_FCHK: begin
        if (stat.kind == K_IMM) begin
          state_nxt = S_PICK;
        end else if (stat.kind == K_REG) begin
          if (stat.out_free) begin
            cmd.op    = OP_FSTORE;
            state_nxt = stat.fg_last ? S_FIN : S_FCHK;
          end
        end else begin
          cmd.op    = OP_FNEXT;
          state_nxt = stat.fg_last ? S_FIN : S_FCHK;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/lgrc_dp.sv @@
// ----------------------------------------------------------------------------
// lgrc_dp
// Guest table, slot table, victim scan and result hold/output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_guest_register_cache_top_macros.svh"

module lgrc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lgrc_pkg::dp_cmd_t               cmd,
  output lgrc_pkg::dp_stat_t              stat,
  input  logic [1:0]                      in_tuser,
  input  logic [lgrc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [1:0]                      out_tuser,
  output logic [lgrc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import lgrc_pkg::*;

  // item latch
  logic [1:0]          cmd_r;
  logic [GUEST_W-1:0]  g_r;
  logic [VAL_W-1:0]    imm_r;

  // guest table
  logic [1:0]            kind_r [GUEST_COUNT];
  logic [SLOT_IDX_W-1:0] gslot_r [GUEST_COUNT];
  logic [VAL_W-1:0]      imm_mem [GUEST_COUNT];
  logic [VAL_W-1:0]      imm_rd_r;

  // slot table
  logic [SLOT_COUNT-1:0] slot_valid_r;
  logic [GUEST_W-1:0]    owner_r [SLOT_COUNT];
  logic [VAL_W-1:0]      age_r [SLOT_COUNT];

  // victim scan and selected slot
  logic [SLOT_IDX_W-1:0] scan_i_r;
  logic [VAL_W-1:0]      best_r;
  logic [SLOT_IDX_W-1:0] sel_r;
  logic [GUEST_W-1:0]    fg_r;

  // hold and output stages
  logic               hold_valid_r;
  logic [1:0]         hold_act_r;
  logic [SLOT_W-1:0]  hold_slot_r;
  logic [GUEST_W-1:0] hold_g_r;
  logic [VAL_W-1:0]   hold_val_r;
  logic               out_valid_r;
  logic [1:0]         out_act_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [GUEST_W-1:0] out_g_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_last_r;

  logic                  flushing;
  logic [GUEST_W-1:0]    cg;
  logic [1:0]            kind_cg;
  logic [SLOT_IDX_W-1:0] cg_slot;
  logic                  has_free;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic                  out_free;
  logic [GUEST_W-1:0]    rd_addr;
  logic                  emit;
  logic [1:0]            e_act;
  logic [SLOT_W-1:0]     e_slot;
  logic [GUEST_W-1:0]    e_g;
  logic [VAL_W-1:0]      e_val;
  logic                  finish;

  // current guest: flush walker or the latched register
  assign flushing = (cmd_r == CMD_FLUSH);
  assign cg       = flushing ? fg_r : g_r;
  assign kind_cg  = kind_r[cg];
  assign cg_slot  = slot_fix(gslot_r[cg]);
  assign out_free = !out_valid_r || out_tready;
  assign finish   = (cmd.op == OP_FINISH);
  assign rd_addr  = (cmd.op == OP_LOAD) ? in_tdata[GUEST_W-1:0] : cg;

  // first free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_IDX_W'(i);
      end
    end
  end

  // status to controller
  always_comb begin
    stat.cmd       = cmd_r;
    stat.gok       = ({1'b0, g_r} < (GUEST_W + 1)'(GUEST_COUNT));
    stat.kind      = kind_cg;
    stat.has_free  = has_free;
    stat.scan_last = (scan_i_r == SLOT_IDX_W'(SLOT_COUNT - 1));
    stat.out_free  = out_free;
    stat.fg_last   = (fg_r == GUEST_W'(GUEST_COUNT - 1));
    stat.flushing  = flushing;
  end

  // result produced by the current operation
  always_comb begin
    emit   = 1'b0;
    e_act  = A_DONE;
    e_slot = '0;
    e_g    = '0;
    e_val  = '0;
    case (cmd.op)
      OP_SET, OP_DONE_ZERO: begin
        emit = 1'b1;
      end
      OP_HIT: begin
        emit   = 1'b1;
        e_slot = SLOT_W'(cg_slot);
        e_g    = g_r;
      end
      OP_SPILL: begin
        emit   = 1'b1;
        e_act  = A_STORE;
        e_slot = SLOT_W'(sel_r);
        e_g    = owner_r[sel_r];
      end
      OP_FILL: begin
        emit   = 1'b1;
        e_act  = (kind_cg == K_IMM) ? A_MOVE : A_LOAD;
        e_slot = SLOT_W'(sel_r);
        e_g    = cg;
        e_val  = (kind_cg == K_IMM) ? imm_rd_r : '0;
      end
      OP_DONE_USE: begin
        emit   = 1'b1;
        e_slot = SLOT_W'(sel_r);
        e_g    = g_r;
      end
      OP_FSTORE: begin
        emit   = 1'b1;
        e_act  = A_STORE;
        e_slot = SLOT_W'(cg_slot);
        e_g    = fg_r;
      end
      default: emit = 1'b0;
    endcase
  end

  // immediate store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SET) imm_mem[g_r] <= imm_r;
    imm_rd_r <= imm_mem[rd_addr];
  end

  // item latch, scan and walker registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      cmd_r <= in_tuser;
      g_r   <= in_tdata[GUEST_W-1:0];
      imm_r <= in_tdata[GUEST_W +: VAL_W];
    end
    if (cmd.op == OP_PICK_FREE) sel_r <= free_idx;
    if (cmd.op == OP_SCAN_CLR) begin
      scan_i_r <= '0;
      best_r   <= '0;
      sel_r    <= '0;
    end
    if (cmd.op == OP_SCAN_STEP) begin
      scan_i_r <= scan_i_r + 1'b1;
      if (age_r[scan_i_r] > best_r) begin
        best_r <= age_r[scan_i_r];
        sel_r  <= scan_i_r;
      end
    end
    if (cmd.op == OP_FCLR) fg_r <= '0;
    if (cmd.op == OP_FSTORE || cmd.op == OP_FNEXT) fg_r <= fg_r + 1'b1;
    if (cmd.op == OP_FILL) gslot_r[cg] <= sel_r;
  end

  // guest kinds and slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GUEST_COUNT; i++) kind_r[i] <= K_NONE;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        owner_r[i] <= '0;
        age_r[i]   <= '0;
      end
      slot_valid_r <= '0;
    end else begin
      case (cmd.op)
        OP_SET: begin
          if (kind_cg == K_REG) begin
            slot_valid_r[cg_slot] <= 1'b0;
            age_r[cg_slot]        <= '0;
          end
          kind_r[g_r] <= K_IMM;
        end
        OP_AGE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (age_r[i] != '1) age_r[i] <= age_r[i] + 1'b1;
          end
        end
        OP_HIT: age_r[cg_slot] <= '0;
        OP_SPILL: kind_r[owner_r[sel_r]] <= K_NONE;
        OP_FILL: begin
          slot_valid_r[sel_r] <= 1'b1;
          owner_r[sel_r]      <= cg;
          age_r[sel_r]        <= '0;
          kind_r[cg]          <= K_REG;
        end
        OP_FSTORE: begin
          slot_valid_r[cg_slot] <= 1'b0;
          age_r[cg_slot]        <= '0;
          kind_r[fg_r]          <= K_NONE;
        end
        OP_FNEXT: kind_r[fg_r] <= K_NONE;
        default: ;
      endcase
    end
  end

  // hold stage: the newest result waits here until its last flag is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        if (hold_valid_r) begin
          out_valid_r <= 1'b1;
          out_act_r   <= hold_act_r;
          out_slot_r  <= hold_slot_r;
          out_g_r     <= hold_g_r;
          out_val_r   <= hold_val_r;
          out_last_r  <= 1'b0;
        end else if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        hold_valid_r <= 1'b1;
        hold_act_r   <= e_act;
        hold_slot_r  <= e_slot;
        hold_g_r     <= e_g;
        hold_val_r   <= e_val;
      end else if (finish) begin
        out_valid_r  <= 1'b1;
        out_act_r    <= hold_valid_r ? hold_act_r  : A_DONE;
        out_slot_r   <= hold_valid_r ? hold_slot_r : '0;
        out_g_r      <= hold_valid_r ? hold_g_r    : '0;
        out_val_r    <= hold_valid_r ? hold_val_r  : '0;
        out_last_r   <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {7'd0, out_val_r, out_g_r, out_slot_r};
  assign out_tlast  = out_last_r;

  `LGRC_ASSERT(a_push_room, ((emit && hold_valid_r) || finish) |-> out_free, "push into busy output")
  `LGRC_ASSERT(a_spill_full, (cmd.op == OP_SPILL) |-> (slot_valid_r[sel_r] && !has_free), "spill with free slot")
  `LGRC_ASSERT_NEXT(a_fill_claims, cmd.op == OP_FILL, slot_valid_r[$past(sel_r)], "fill left slot free")
  `LGRC_ASSERT_NEXT(a_finish_drains, cmd.op == OP_FINISH, !hold_valid_r && out_valid_r && out_last_r, "finish did not drain hold")

endmodule

@@ hw/rtl/lru_guest_register_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_guest_register_cache_top
// LRU cache of 32 guest registers over 9 host slots.
//
//  channel  dir  tdata                               tuser       tlast
//  in_      in   [4:0] guest_reg, [36:5] imm_value   [1:0] cmd   -
//  out_     out  [3:0] slot, [8:4] guest_index,      [1:0] action last
//                [40:9] move_value
//
// One command at a time; in_tready is high only while the sequencer is idle.
// A use miss with all slots full adds an age scan over the nine slots and a spill.
// Flush walks the 32 guest entries one per cycle while the output accepts results,
// and binds each held immediate to a slot first, evicting one when all are full.
// Output stalls hold the sequencer at its next result; reset is synchronous,
// active low, and leaves all entries not loaded and all slots free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_guest_register_cache_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lgrc_pkg::IN_DATA_W-1:0]  in_tdata,   // guest_reg, imm_value
  input  logic [1:0]                      in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lgrc_pkg::OUT_DATA_W-1:0] out_tdata,  // slot, guest_index, move_value
  output logic [1:0]                      out_tuser,  // action
  output logic                            out_tlast
);
  import lgrc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  lgrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, scan and result registers
  lgrc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the guest register cache. Commands stream in from a
// queue with random gaps; a behavioral copy of the cache predicts each result
// transaction, and a monitor compares them in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lgrc_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  greg;
    logic [31:0] imm;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [4:0]  gidx;
    logic [31:0] mval;
    logic        last;
  } cache_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  lru_guest_register_cache_top dut (.*);

  // predictor state
  logic [1:0]  p_kind [GUEST_COUNT];
  logic [3:0]  p_gslot[GUEST_COUNT];
  logic [31:0] p_imm  [GUEST_COUNT];
  logic        p_sval [SLOT_COUNT];
  logic [4:0]  p_owner[SLOT_COUNT];
  logic [31:0] p_age  [SLOT_COUNT];

  cmd_item_t  cmd_q[$];
  cache_res_t exp_q[$];
  int         errors = 0;
  int         stall_cnt = 0;
  int         idle_cycles = 0;
  bit         hold_off = 0;
  bit         in_fire = 0;
  bit         out_fire = 0;

  function automatic void push_res(logic [1:0] a, logic [3:0] s, logic [4:0] g,
                                   logic [31:0] v);
    cache_res_t r;
    r = '{a, s, g, v, 1'b0};
    exp_q.push_back(r);
  endfunction

  function automatic int oldest_slot();
    logic [31:0] best;
    int idx;
    best = 0;
    idx = 0;
    for (int a = 0; a < SLOT_COUNT; a++)
      if (p_age[a] > best) begin
        best = p_age[a];
        idx = a;
      end
    return idx;
  endfunction

  function automatic int first_free();
    for (int a = 0; a < SLOT_COUNT; a++)
      if (!p_sval[a]) return a;
    return -1;
  endfunction

  function automatic void claim_slot(int s, int g);
    p_sval[s] = 1'b1;
    p_owner[s] = g[4:0];
    p_age[s] = 0;
    p_kind[g] = K_REG;
    p_gslot[g] = s[3:0];
  endfunction

  // pick a slot (free or evicted) and move the held immediate into it
  function automatic int bind_imm(int g);
    int victim, f, s;
    victim = oldest_slot();
    f = first_free();
    if (f >= 0) s = f;
    else begin
      s = victim;
      push_res(A_STORE, s[3:0], p_owner[s], '0);
      p_kind[p_owner[s]] = K_NONE;
    end
    push_res(A_MOVE, s[3:0], g[4:0], p_imm[g]);
    claim_slot(s, g);
    return s;
  endfunction

  function automatic int slot_of(int g);
    return (p_gslot[g] < SLOT_COUNT) ? p_gslot[g] : 0;
  endfunction

  function automatic void predict_cache(cmd_item_t it);
    int g, s, f, victim, n0;
    g = it.greg;
    n0 = exp_q.size();
    if (it.cmd == CMD_USE) begin
      if (p_kind[g] == K_IMM) begin
        s = bind_imm(g);
        push_res(A_DONE, s[3:0], g[4:0], '0);
      end else begin
        for (int a = 0; a < SLOT_COUNT; a++)
          if (p_age[a] != 32'hFFFF_FFFF) p_age[a]++;
        victim = oldest_slot();
        if (p_kind[g] == K_REG) begin
          s = slot_of(g);
          p_age[s] = 0;
          push_res(A_DONE, s[3:0], g[4:0], '0);
        end else begin
          f = first_free();
          if (f >= 0) s = f;
          else begin
            s = victim;
            push_res(A_STORE, s[3:0], p_owner[s], '0);
            p_kind[p_owner[s]] = K_NONE;
          end
          push_res(A_LOAD, s[3:0], g[4:0], '0);
          claim_slot(s, g);
          push_res(A_DONE, s[3:0], g[4:0], '0);
        end
      end
    end else if (it.cmd == CMD_SET) begin
      if (p_kind[g] == K_REG) begin
        s = slot_of(g);
        p_sval[s] = 1'b0;
        p_age[s] = 0;
      end
      p_kind[g] = K_IMM;
      p_imm[g] = it.imm;
      push_res(A_DONE, '0, '0, '0);
    end else if (it.cmd == CMD_FLUSH) begin
      for (int i = 0; i < GUEST_COUNT; i++) begin
        if (p_kind[i] == K_IMM) s = bind_imm(i);
        if (p_kind[i] == K_REG) begin
          s = slot_of(i);
          push_res(A_STORE, s[3:0], i[4:0], '0);
          p_sval[s] = 1'b0;
          p_age[s] = 0;
        end
        p_kind[i] = K_NONE;
      end
      if (exp_q.size() == n0) push_res(A_DONE, '0, '0, '0);
    end else begin
      push_res(A_DONE, '0, '0, '0);
    end
    exp_q[exp_q.size()-1].last = 1'b1;
  endfunction

  function automatic void add_cmd(logic [1:0] c, logic [4:0] g, logic [31:0] v);
    cmd_item_t it;
    it = '{c, g, v};
    cmd_q.push_back(it);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: one command per transaction, random gap after each
  int gap_cnt = 0;
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    for (int i = 0; i < GUEST_COUNT; i++) begin
      p_kind[i] = K_NONE;
      p_gslot[i] = '0;
      p_imm[i] = '0;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      p_sval[i] = 1'b0;
      p_owner[i] = '0;
      p_age[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  // handshakes seen at the last rising edge
  always @(posedge clk) begin
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // transaction still waiting for acceptance
    end else if (hold_off || cmd_q.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (gap_cnt > 0) begin
      in_tvalid <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else begin
      in_tvalid <= 1'b1;
      in_tuser <= cmd_q[0].cmd;
      in_tdata <= {3'b0, cmd_q[0].imm, cmd_q[0].greg};
      cmd_q.pop_front();
      gap_cnt <= $urandom_range(0, 3);
    end
  end

  // receiver stalls, drawn after each accepted result
  always @(negedge clk) begin
    int st;
    if (rst_n) begin
      if (out_fire) begin
        st = $urandom_range(0, 3);
        stall_cnt <= (st > 0) ? st - 1 : 0;
        out_tready <= (st == 0);
      end else if (stall_cnt > 0) begin
        out_tready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    cache_res_t got, want;
    cmd_item_t acc;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        acc = '{in_tuser, in_tdata[4:0], in_tdata[36:5]};
        predict_cache(acc);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[3:0], out_tdata[8:4], out_tdata[40:9], out_tlast};
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = exp_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp act=%0d slot=%0d g=%0d v=%h last=%0d, ",
                        "got act=%0d slot=%0d g=%0d v=%h last=%0d"},
                       want.action, want.slot, want.gidx, want.mval, want.last,
                       got.action, got.slot, got.gidx, got.mval, got.last);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    int kind;
    wait (rst_n);
    // directed: fill beyond nine slots, hit, evict, immediates, edge values
    for (int g = 0; g < 11; g++) add_cmd(CMD_USE, g[4:0], '0);
    add_cmd(CMD_USE, 5'd3, '0);
    add_cmd(CMD_USE, 5'd31, '0);
    add_cmd(CMD_SET, 5'd31, 32'hFFFF_FFFF);
    add_cmd(CMD_SET, 5'd0, 32'h0);
    add_cmd(CMD_SET, 5'd20, 32'hA5A5_5A5A);
    add_cmd(CMD_USE, 5'd31, '0);
    add_cmd(CMD_USE, 5'd31, '0);
    add_cmd(2'd3, 5'd31, 32'hFFFF_FFFF);
    add_cmd(CMD_FLUSH, '0, '0);
    add_cmd(CMD_FLUSH, '0, '0);
    add_cmd(CMD_USE, 5'd0, '0);
    wait (cmd_q.size() == 0);
    // hold the sender until every expected result has drained
    @(negedge clk) hold_off = 1'b1;
    wait (exp_q.size() == 0 && !in_tvalid);
    @(negedge clk) hold_off = 1'b0;
    for (int i = 0; i < 210; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60)
        add_cmd(CMD_USE, (i % 3 == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 13)),
                '0);
      else if (kind < 85)
        add_cmd(CMD_SET, 5'($urandom_range(0, 31)), $urandom());
      else if (kind < 95) add_cmd(CMD_FLUSH, 5'($urandom_range(0, 31)), $urandom());
      else add_cmd(2'd3, 5'($urandom_range(0, 31)), $urandom());
    end
    wait (cmd_q.size() == 0);
    wait (!in_tvalid);
    wait (exp_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lgrc_pkg.sv
hw/rtl/lgrc_ctrl.sv
hw/rtl/lgrc_dp.sv
hw/rtl/lru_guest_register_cache_top.sv
test/tb_top.sv
